FILE: rtl/rotenc_pkg.sv
// Shared types, constants and the quadrature transition table for the
// rotary encoder detent decoder. No dependencies.
`default_nettype none

package rotenc_pkg;

	// sample beat, first field in the MSBs
	typedef struct packed {
		logic        level_a;
		logic        level_b;
		logic        button_level;
		logic [31:0] time_us;
	} sample_t;

	// result beat
	typedef struct packed {
		logic signed [2:0] count_delta;
		logic              is_pressed;
		logic              changed;
	} result_t;

	// one entry of a line's pulse queue
	typedef struct packed {
		logic [31:0] start;
		logic        level;
		logic        pending;
		logic [1:0]  code;
	} qentry_t;

	// code write-back from the merge unit into a line's queue
	typedef struct packed {
		logic       en;
		logic       idx;
		logic [1:0] code;
	} qwr_t;

	// merge unit status toward the top level
	typedef struct packed {
		logic              busy;
		logic              stepped;
		logic signed [3:0] count;
	} mstat_t;

	// configuration register indexes
	localparam logic CFG_MIN_HIGH       = 1'b0;
	localparam logic CFG_PRESS_DEBOUNCE = 1'b1;

	localparam logic [15:0] MIN_HIGH_RST       = 16'd500;
	localparam logic [15:0] PRESS_DEBOUNCE_RST = 16'd1000;

	// transition flags
	localparam logic [5:0] FL_CW_FIRST  = 6'h01;
	localparam logic [5:0] FL_CCW_FIRST = 6'h02;
	localparam logic [5:0] FL_CW_LAST   = 6'h04;
	localparam logic [5:0] FL_CCW_LAST  = 6'h08;
	localparam logic [5:0] FL_MIDDLE    = 6'h10;
	localparam logic [5:0] FL_DETENT    = 6'h20;
	localparam logic [5:0] FL_NONE      = 6'h00;

	localparam logic [5:0] CW_NEEDED  = FL_CW_FIRST | FL_CW_LAST | FL_MIDDLE;
	localparam logic [5:0] CCW_NEEDED = FL_CCW_FIRST | FL_CCW_LAST | FL_MIDDLE;

	localparam logic [1:0] CODE_DETENT = 2'b11;

	// row = previous code {B,A}, column = new code {B,A}
	function automatic logic [5:0] trans_flags(input logic [1:0] prev, input logic [1:0] nxt);
		logic [5:0] f;
		f = FL_NONE;
		if (nxt == CODE_DETENT) begin
			f = FL_DETENT;
		end else begin
			case (prev)
				2'd0: begin
					case (nxt)
						2'd1:    f = FL_CW_LAST;
						2'd2:    f = FL_CCW_LAST;
						default: f = FL_NONE;
					endcase
				end
				2'd1, 2'd2: begin
					f = (nxt == 2'd0) ? FL_MIDDLE : FL_NONE;
				end
				2'd3: begin
					case (nxt)
						2'd1:    f = FL_CCW_FIRST;
						2'd2:    f = FL_CW_FIRST;
						default: f = FL_NONE;
					endcase
				end
				default: f = FL_NONE;
			endcase
		end
		return f;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/rotary_encoder_detent_decoder_unit.sv
// Top level of the rotary encoder detent decoder: handshake, sequencer,
// button debounce, config registers and result register.
// Depends on rotenc_pkg, rotenc_line and rotenc_merge.
`default_nettype none

// Decodes quadrature encoder samples into detent steps. Each sample beat
// (lines A/B, active-low button, microsecond timestamp) yields exactly one
// result beat: signed count delta saturated to +/-2, debounced press level
// and a changed flag. A beat goes through capture, line/button update and
// result load when no line queue updates, and through capture, update, the
// walk, the sequencer seeing the walk end and result load when one does:
// the four queued pulses are walked one per cycle through a single shared
// start-time compare and transition-table lookup. A stalled result holds up
// the sequencer only when the next beat is ready to load. The result sits
// in an output register, so the next sample is taken while it waits.
// Register 0 is min_high_us, register 1 is press_debounce_us; write them
// only while idle. cfg_ready is always high.

module rotary_encoder_detent_decoder_unit
	import rotenc_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	// sample channel
	input  wire logic    sample_valid,
	output      logic    sample_stall,
	input  wire sample_t sample,
	// result channel
	output      logic    result_valid,
	input  wire logic    result_stall,
	output      result_t result,
	// config write channel
	input  wire logic    cfg_valid,
	output      logic    cfg_ready,
	input  wire logic    cfg_index,
	input  wire logic [15:0] cfg_data
);

	// sequencer states, one-hot
	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_UPDATE = 4'b0010,
		ST_MERGE  = 4'b0100,
		ST_DONE   = 4'b1000
	} state_t;

	state_t  state_q;
	sample_t sample_q;
	logic    upd_q;
	logic    press_chg_q;

	logic [15:0] min_high_q;
	logic [15:0] press_debounce_q;

	logic        pressed_q;
	logic [31:0] press_start_q;

	result_t result_q;
	logic    result_valid_q;

	logic          line_en;
	logic          ua;
	logic          ub;
	qentry_t [1:0] qa;
	qentry_t [1:0] qb;
	qwr_t          wr_a;
	qwr_t          wr_b;
	mstat_t        mstat;
	logic          merge_start;

	logic              in_beat;
	logic              out_free;
	logic              btn_down;
	logic [31:0]       press_age;
	logic              press_hold;
	logic signed [2:0] delta_sat;

	assign in_beat  = sample_valid && !sample_stall;
	assign out_free = !result_valid_q || !result_stall;

	assign sample_stall = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign cfg_ready    = 1'b1;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_high_q       <= MIN_HIGH_RST;
			press_debounce_q <= PRESS_DEBOUNCE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MIN_HIGH:       min_high_q       <= cfg_data;
				CFG_PRESS_DEBOUNCE: press_debounce_q <= cfg_data;
				default:            min_high_q       <= min_high_q;
			endcase
		end
	end

	// line trackers update once per beat, in ST_UPDATE
	assign line_en = (state_q == ST_UPDATE);

	rotenc_line u_line_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (line_en),
		.lvl      (sample_q.level_a),
		.now      (sample_q.time_us),
		.min_high (min_high_q),
		.wr       (wr_a),
		.upd      (ua),
		.queue    (qa)
	);

	rotenc_line u_line_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (line_en),
		.lvl      (sample_q.level_b),
		.now      (sample_q.time_us),
		.min_high (min_high_q),
		.wr       (wr_b),
		.upd      (ub),
		.queue    (qb)
	);

	// merge only runs when at least one queue took new pulses
	assign merge_start = line_en && (ua || ub);

	rotenc_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (merge_start),
		.qa     (qa),
		.qb     (qb),
		.wr_a   (wr_a),
		.wr_b   (wr_b),
		.stat   (mstat)
	);

	// Button: a registered press is held for the debounce time. The release
	// is taken on the first sample after the hold, no debounce on release.
	assign btn_down   = !sample_q.button_level;
	assign press_age  = sample_q.time_us - press_start_q;
	assign press_hold = pressed_q && (press_age < {16'd0, press_debounce_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q     <= 1'b0;
			press_start_q <= '0;
			press_chg_q   <= 1'b0;
		end else if (line_en) begin
			press_chg_q <= 1'b0;
			if (!press_hold) begin
				if (btn_down && !pressed_q) begin
					pressed_q     <= 1'b1;
					press_start_q <= sample_q.time_us;
					press_chg_q   <= 1'b1;
				end else if (!btn_down && pressed_q) begin
					pressed_q   <= 1'b0;
					press_chg_q <= 1'b1;
				end
			end
		end
	end

	// saturate the merge count (-4..4) to -2..2
	always_comb begin
		if (!upd_q) begin
			delta_sat = 3'sd0;
		end else if (mstat.count > 4'sd2) begin
			delta_sat = 3'sd2;
		end else if (mstat.count < -4'sd2) begin
			delta_sat = -3'sd2;
		end else begin
			delta_sat = mstat.count[2:0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			upd_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					upd_q   <= ua || ub;
					state_q <= (ua || ub) ? ST_MERGE : ST_DONE;
				end
				ST_MERGE: begin
					if (!mstat.busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// capture the sample beat; payload needs no reset
	always_ff @(posedge clk) begin
		if (in_beat) begin
			sample_q <= sample;
		end
	end

	// result register: loads from ST_DONE, holds while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			result_q.count_delta <= delta_sat;
			result_q.is_pressed  <= pressed_q;
			result_q.changed     <= press_chg_q || (upd_q && mstat.stepped);
		end
	end

	// merge unit only runs while the sequencer waits on it
	a_busy_in_merge: assert property (@(posedge clk) disable iff (!arst_n)
		mstat.busy |-> (state_q == ST_MERGE))
		else $error("merge busy outside merge state");

	// a merge walks exactly four queue entries
	a_merge_len: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(mstat.busy) |-> ##3 mstat.busy ##1 !mstat.busy)
		else $error("merge did not take four steps");

	// a finished beat with room in the result register yields a result
	a_done_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> result_valid)
		else $error("result not loaded");

	// delta stays saturated
	a_delta_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.count_delta != 3'b011 && result.count_delta != 3'b100))
		else $error("count delta out of range");

endmodule

`default_nettype wire

FILE: rtl/rotenc_line.sv
// Per-line high-pulse qualifier and two-entry pulse queue.
// Depends on rotenc_pkg.
`default_nettype none

module rotenc_line
	import rotenc_pkg::*;
(
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           lvl,
	input  wire logic [31:0]    now,
	input  wire logic [15:0]    min_high,
	input  wire qwr_t           wr,
	output      logic           upd,
	output      qentry_t [1:0]  queue
);

	logic [31:0]   pulse_start_q;
	logic          pulse_level_q;
	logic [31:0]   last_high_end_q;
	qentry_t [1:0] queue_q;

	logic [31:0] elapsed;
	logic        hi_done;

	assign elapsed = now - pulse_start_q;
	assign hi_done = pulse_level_q && (elapsed > {16'd0, min_high});
	// a high pulse that continues the last counted one leaves the queue alone
	assign upd     = en && hi_done && (last_high_end_q != pulse_start_q);
	assign queue   = queue_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_start_q   <= '0;
			pulse_level_q   <= 1'b1;
			last_high_end_q <= '0;
			queue_q         <= '0;
		end else if (en) begin
			if (hi_done) begin
				if (upd) begin
					queue_q[0].start   <= last_high_end_q;
					queue_q[0].level   <= 1'b0;
					queue_q[0].pending <= 1'b1;
					queue_q[1].start   <= pulse_start_q;
					queue_q[1].level   <= pulse_level_q;
					queue_q[1].pending <= 1'b1;
				end
				last_high_end_q <= now;
				pulse_start_q   <= now;
				pulse_level_q   <= lvl;
			end else if (lvl != pulse_level_q) begin
				pulse_start_q <= now;
				pulse_level_q <= lvl;
			end
		end else if (wr.en) begin
			queue_q[wr.idx].code    <= wr.code;
			queue_q[wr.idx].pending <= 1'b0;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/rotenc_merge.sv
// Merge sequencer: walks the four queued pulses oldest-first, one per
// cycle, through one compare and one transition-table lookup. Depends on rotenc_pkg.
`default_nettype none

module rotenc_merge
	import rotenc_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire qentry_t [1:0] qa,
	input  wire qentry_t [1:0] qb,
	output      qwr_t          wr_a,
	output      qwr_t          wr_b,
	output      mstat_t        stat
);

	logic              busy_q;
	logic [1:0]        ia_q;
	logic [1:0]        ib_q;
	logic              replay_q;
	logic [5:0]        seen_q;
	logic signed [3:0] count_q;
	logic              stepped_q;
	logic [1:0]        last_code_q;

	qentry_t    ea;
	qentry_t    eb;
	qentry_t    e;
	logic       take_a;
	logic       do_replay;
	logic [1:0] code_n;
	logic [5:0] flags;
	logic       is_cw;
	logic       is_ccw;
	logic       last_step;

	assign ea = qa[ia_q[0]];
	assign eb = qb[ib_q[0]];

	// B wins ties; once one side is used up the other drains
	assign take_a    = ib_q[1] || (!ia_q[1] && (ea.start < eb.start));
	assign e         = take_a ? ea : eb;
	assign do_replay = replay_q && !e.pending;

	always_comb begin
		if (do_replay) begin
			code_n = e.code;
		end else if (take_a) begin
			code_n = {last_code_q[1], e.level};
		end else begin
			code_n = {e.level, last_code_q[0]};
		end
	end

	assign flags  = trans_flags(last_code_q, code_n);
	assign is_ccw = (seen_q & CCW_NEEDED) == CCW_NEEDED;
	assign is_cw  = (seen_q & CW_NEEDED) == CW_NEEDED;

	assign last_step = ({1'b0, ia_q} + {1'b0, ib_q}) == 3'd3;

	always_comb begin
		wr_a      = '0;
		wr_b      = '0;
		wr_a.idx  = ia_q[0];
		wr_b.idx  = ib_q[0];
		wr_a.code = code_n;
		wr_b.code = code_n;
		wr_a.en   = busy_q && !do_replay && take_a;
		wr_b.en   = busy_q && !do_replay && !take_a;
	end

	assign stat.busy    = busy_q;
	assign stat.stepped = stepped_q;
	assign stat.count   = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			ia_q        <= '0;
			ib_q        <= '0;
			replay_q    <= 1'b1;
			seen_q      <= '0;
			count_q     <= '0;
			stepped_q   <= 1'b0;
			last_code_q <= CODE_DETENT;
		end else if (start) begin
			busy_q    <= 1'b1;
			ia_q      <= '0;
			ib_q      <= '0;
			replay_q  <= 1'b1;
			seen_q    <= '0;
			count_q   <= '0;
			stepped_q <= 1'b0;
		end else if (busy_q) begin
			if (take_a) begin
				ia_q <= ia_q + 2'd1;
			end else begin
				ib_q <= ib_q + 2'd1;
			end
			if (last_step) begin
				busy_q <= 1'b0;
			end
			last_code_q <= code_n;
			if (do_replay) begin
				if (flags != FL_DETENT) begin
					seen_q <= seen_q | flags;
				end
			end else begin
				replay_q <= 1'b0;
				if (flags == FL_DETENT) begin
					if (is_ccw) begin
						count_q   <= count_q - 4'sd1;
						seen_q    <= '0;
						stepped_q <= 1'b1;
					end else if (is_cw) begin
						count_q   <= count_q + 4'sd1;
						seen_q    <= '0;
						stepped_q <= 1'b1;
					end
				end else begin
					seen_q <= seen_q | flags;
				end
			end
		end
	end

endmodule

`default_nettype wire
